// ----- sv/cmp_pkg.sv -----
// Shared constants and types for the cosine motion profile block.
package cmp_pkg;

   localparam int ANG_W        = 33;
   localparam int CORDIC_STEPS = 30;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;

   localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [ANG_W-1:0] ONE_Q30     = 33'sd1073741824;

   localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
      32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
      32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
      32'd32,        32'd16,        32'd8,         32'd4,         32'd2
   };

   typedef enum logic [1:0] {
      CSR_START    = 2'd0,
      CSR_END      = 2'd1,
      CSR_DURATION = 2'd2
   } cmp_csr_type;

   typedef struct packed {
      logic        done;
      logic        cneg;
   } cmp_ang_type;

   typedef struct packed {
      logic        done;
      logic [47:0] acc;
      logic [47:0] vel;
      logic [31:0] pos;
   } cmp_rsp_type;

endpackage

// ----- sv/cmp_div.sv -----
// Pipelined restoring divider that resolves one quotient bit per stage.
module cmp_div #(
   parameter int QUO_W  = 52,
   parameter int DEN_W  = 24,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              vld_i,
   input  logic [DEN_W-1:0]  rem_i,
   input  logic [QUO_W-1:0]  num_i,
   input  logic [DEN_W-1:0]  den_i,
   input  logic [SIDE_W-1:0] side_i,
   output logic              vld_o,
   output logic [QUO_W-1:0]  quo_o,
   output logic [SIDE_W-1:0] side_o
);

   logic              vld_ff  [QUO_W];
   logic [DEN_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  wrd_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   logic              vld_p   [QUO_W];
   logic [DEN_W-1:0]  rem_p   [QUO_W];
   logic [QUO_W-1:0]  wrd_p   [QUO_W];
   logic [SIDE_W-1:0] side_p  [QUO_W];
   logic [DEN_W-1:0]  rem_in  [QUO_W];
   logic [QUO_W-1:0]  wrd_in  [QUO_W];

   always_comb begin
      vld_p[0]  = vld_i;
      rem_p[0]  = rem_i;
      wrd_p[0]  = num_i;
      side_p[0] = side_i;
      for (int i = 1; i < QUO_W; i++) begin
         vld_p[i]  = vld_ff[i-1];
         rem_p[i]  = rem_ff[i-1];
         wrd_p[i]  = wrd_ff[i-1];
         side_p[i] = side_ff[i-1];
      end
   end

   always_comb begin
      logic [DEN_W:0] trial;
      logic           ge;
      for (int i = 0; i < QUO_W; i++) begin
         trial = {rem_p[i], wrd_p[i][QUO_W-1]};
         ge    = (trial >= {1'b0, den_i});
         rem_in[i] = ge ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
         wrd_in[i] = {wrd_p[i][QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUO_W; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_p[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < QUO_W; i++) begin
            rem_ff[i]  <= rem_in[i];
            wrd_ff[i]  <= wrd_in[i];
            side_ff[i] <= side_p[i];
         end
      end
   end

   assign vld_o  = vld_ff[QUO_W-1];
   assign quo_o  = wrd_ff[QUO_W-1];
   assign side_o = side_ff[QUO_W-1];

endmodule

// ----- sv/cmp_cordic.sv -----
// Pipelined rotation-mode CORDIC that yields cosine and sine in Q30.
module cmp_cordic import cmp_pkg::*; #(
   parameter int SIDE_W = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    vld_i,
   input  logic signed [ANG_W-1:0] z_i,
   input  logic [SIDE_W-1:0]       side_i,
   output logic                    vld_o,
   output logic signed [ANG_W-1:0] x_o,
   output logic signed [ANG_W-1:0] y_o,
   output logic [SIDE_W-1:0]       side_o
);

   logic                    vld_ff  [CORDIC_STEPS];
   logic signed [ANG_W-1:0] x_ff    [CORDIC_STEPS];
   logic signed [ANG_W-1:0] y_ff    [CORDIC_STEPS];
   logic signed [ANG_W-1:0] z_ff    [CORDIC_STEPS];
   logic [SIDE_W-1:0]       side_ff [CORDIC_STEPS];

   logic                    vld_p   [CORDIC_STEPS];
   logic signed [ANG_W-1:0] x_p     [CORDIC_STEPS];
   logic signed [ANG_W-1:0] y_p     [CORDIC_STEPS];
   logic signed [ANG_W-1:0] z_p     [CORDIC_STEPS];
   logic [SIDE_W-1:0]       side_p  [CORDIC_STEPS];
   logic signed [ANG_W-1:0] x_in    [CORDIC_STEPS];
   logic signed [ANG_W-1:0] y_in    [CORDIC_STEPS];
   logic signed [ANG_W-1:0] z_in    [CORDIC_STEPS];

   always_comb begin
      vld_p[0]  = vld_i;
      x_p[0]    = CORDIC_GAIN;
      y_p[0]    = '0;
      z_p[0]    = z_i;
      side_p[0] = side_i;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
         vld_p[i]  = vld_ff[i-1];
         x_p[i]    = x_ff[i-1];
         y_p[i]    = y_ff[i-1];
         z_p[i]    = z_ff[i-1];
         side_p[i] = side_ff[i-1];
      end
   end

   always_comb begin
      logic signed [ANG_W-1:0] dx;
      logic signed [ANG_W-1:0] dy;
      logic signed [ANG_W-1:0] at;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y_p[i] >>> i;
         dy = x_p[i] >>> i;
         at = $signed({{(ANG_W-32){1'b0}}, ATAN_Q30[i]});
         if (!z_p[i][ANG_W-1]) begin
            x_in[i] = x_p[i] - dx;
            y_in[i] = y_p[i] + dy;
            z_in[i] = z_p[i] - at;
         end else begin
            x_in[i] = x_p[i] + dx;
            y_in[i] = y_p[i] - dy;
            z_in[i] = z_p[i] + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_p[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            side_ff[i] <= side_p[i];
         end
      end
   end

   assign vld_o  = vld_ff[CORDIC_STEPS-1];
   assign x_o    = x_ff[CORDIC_STEPS-1];
   assign y_o    = y_ff[CORDIC_STEPS-1];
   assign side_o = side_ff[CORDIC_STEPS-1];

endmodule

// ----- sv/cosine_motion_profile.sv -----
// Top level of the cosine motion profile: phase, CORDIC, scaling and output queue.
// Throughput is one item per cycle; the pipeline advances as one unit while the
// two-entry output queue has room, so input transfers continue while a result waits.
// Reset is synchronous and active high; it empties the pipeline and the output queue
// and sets start and end position to 0 and the duration to 1.
module cosine_motion_profile import cmp_pkg::*; #(
   parameter int PHASE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // [23:0] elapsed_ticks
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [31:0] position, [79:32] velocity, [127:80] acceleration
   output logic         rsp_tuser,   // [0] move_done
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int QP_W  = PHASE_BITS + 1;
   localparam int NUM_W = PHASE_BITS + 25;
   localparam int ZW    = PHASE_BITS + 33;
   localparam logic [QP_W-1:0] PH_FULL = QP_W'(1) << PHASE_BITS;
   localparam logic [QP_W-1:0] PH_HALF = QP_W'(1) << (PHASE_BITS - 1);
   localparam logic [51:0] SAT_POS = 52'h7FFF_FFFF_FFFF;
   localparam logic [51:0] SAT_NEG = 52'h8000_0000_0000;

   function automatic logic [30:0] clamp_q30(input logic signed [ANG_W-1:0] v);
      logic [30:0] r;
      if (v[ANG_W-1]) begin
         r = '0;
      end else if (v > ONE_Q30) begin
         r = 31'(ONE_Q30);
      end else begin
         r = 31'(v);
      end
      return r;
   endfunction

   function automatic logic [47:0] sat48(input logic neg, input logic [51:0] q);
      logic [52:0] r;
      logic [51:0] m;
      r = (53'(q) + 53'd1) >> 1;
      m = r[51:0];
      if (neg) begin
         if (m > SAT_NEG) m = SAT_NEG;
         m = 52'd0 - m;
      end else begin
         if (m > SAT_POS) m = SAT_POS;
      end
      return m[47:0];
   endfunction

   // Configuration registers and values derived from them.
   logic signed [31:0] start_ff;
   logic signed [31:0] end_ff;
   logic [23:0]        dur_ff;
   logic [23:0]        teff;
   logic signed [32:0] dif_w;
   logic signed [32:0] dif_ff;
   logic               difneg_ff;
   logic [31:0]        difmag_ff;
   logic [63:0]        magpi_ff;
   logic [63:0]        mp2lo_ff;
   logic [63:0]        mp2hi_ff;
   logic [95:0]        magpi2_ff;
   logic [47:0]        tsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         dur_ff   <= 24'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START:    start_ff <= csr_wdata;
            CSR_END:      end_ff   <= csr_wdata;
            CSR_DURATION: dur_ff   <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   assign teff  = (dur_ff == '0) ? 24'd1 : dur_ff;
   assign dif_w = 33'(end_ff) - 33'(start_ff);

   always_ff @(posedge clock) begin
      dif_ff    <= dif_w;
      difneg_ff <= dif_w[32];
      difmag_ff <= dif_w[32] ? 32'(-dif_w) : 32'(dif_w);
      magpi_ff  <= 64'(difmag_ff) * 64'(PI_Q30);
      mp2lo_ff  <= 64'(magpi_ff[31:0]) * 64'(PI_Q30);
      mp2hi_ff  <= 64'(magpi_ff[63:32]) * 64'(PI_Q30);
      magpi2_ff <= {mp2hi_ff, 32'b0} + 96'(mp2lo_ff);
      tsq_ff    <= 48'(teff) * 48'(teff);
   end

   // Global advance: the pipeline moves whenever the output queue has room.
   logic [1:0] cnt_ff;
   logic       en;

   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;

   // Input stage.
   logic              s0_vld_ff;
   logic [23:0]       s0_t_ff;
   logic [NUM_W-1:0]  ph_num;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_t_ff <= req_tdata;
      end
   end

   assign ph_num = {1'b0, s0_t_ff, PHASE_BITS'(0)} + NUM_W'(teff >> 1);

   logic            ph_vld;
   logic [QP_W-1:0] ph_q;
   logic            ph_done;

   cmp_div #(
      .QUO_W  (QP_W),
      .DEN_W  (24),
      .SIDE_W (1)
   ) u_phase_div (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (s0_vld_ff),
      .rem_i  (ph_num[NUM_W-1:QP_W]),
      .num_i  (ph_num[QP_W-1:0]),
      .den_i  (teff),
      .side_i (s0_t_ff > teff),
      .vld_o  (ph_vld),
      .quo_o  (ph_q),
      .side_o (ph_done)
   );

   // Fold to the first quarter and scale the phase to a Q30 angle.
   logic [PHASE_BITS-1:0]   pf;
   logic                    fold;
   logic [ZW-1:0]           zprod;
   logic signed [ANG_W-1:0] z_in;
   logic                    zs_vld_ff;
   logic signed [ANG_W-1:0] z_ff;
   cmp_ang_type             zs_ang_ff;

   always_comb begin
      fold  = (ph_q > PH_HALF);
      pf    = fold ? PHASE_BITS'(PH_FULL - ph_q) : PHASE_BITS'(ph_q);
      zprod = ZW'(pf) * ZW'(PI_Q30) + ZW'(PH_HALF);
      z_in  = ANG_W'(zprod >> PHASE_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zs_vld_ff <= 1'b0;
      end else if (en) begin
         zs_vld_ff <= ph_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff           <= z_in;
         zs_ang_ff.done <= ph_done;
         zs_ang_ff.cneg <= fold;
      end
   end

   logic                    co_vld;
   logic signed [ANG_W-1:0] co_x;
   logic signed [ANG_W-1:0] co_y;
   cmp_ang_type             co_ang;

   cmp_cordic #(
      .SIDE_W ($bits(cmp_ang_type))
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (zs_vld_ff),
      .z_i    (z_ff),
      .side_i (zs_ang_ff),
      .vld_o  (co_vld),
      .x_o    (co_x),
      .y_o    (co_y),
      .side_o (co_ang)
   );

   // Clamp and form the partial products.
   logic [30:0]        c_cl;
   logic [30:0]        s_cl;
   logic signed [31:0] cfull;
   logic [31:0]        om;
   logic signed [32:0] om_s;
   logic               sc_vld_ff;
   logic               sc_done_ff;
   logic               sc_cneg_ff;
   logic signed [65:0] pp_ff;
   logic [62:0]        vlo_ff;
   logic [62:0]        vhi_ff;
   logic [62:0]        a0_ff;
   logic [62:0]        a1_ff;
   logic [62:0]        a2_ff;

   always_comb begin
      c_cl  = clamp_q30(co_x);
      s_cl  = clamp_q30(co_y);
      cfull = {1'b0, c_cl};
      if (co_ang.cneg) cfull = -cfull;
      om    = 32'h4000_0000 - 32'(cfull);
      om_s  = {1'b0, om};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_vld_ff <= 1'b0;
      end else if (en) begin
         sc_vld_ff <= co_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_done_ff <= co_ang.done;
         sc_cneg_ff <= co_ang.cneg;
         pp_ff      <= 66'(dif_ff) * 66'(om_s);
         vlo_ff     <= 63'(magpi_ff[31:0]) * 63'(s_cl);
         vhi_ff     <= 63'(magpi_ff[63:32]) * 63'(s_cl);
         a0_ff      <= 63'(magpi2_ff[31:0]) * 63'(c_cl);
         a1_ff      <= 63'(magpi2_ff[63:32]) * 63'(c_cl);
         a2_ff      <= 63'(magpi2_ff[95:64]) * 63'(c_cl);
      end
   end

   // Sum the partial products and finish the position.
   logic signed [65:0] pr;
   logic [94:0]        vx;
   logic [126:0]       ay;
   logic               sd_vld_ff;
   logic               sd_done_ff;
   logic               sd_cneg_ff;
   logic signed [31:0] sd_pos_ff;
   logic [51:0]        sd_vnum_ff;
   logic [51:0]        sd_anum_ff;

   always_comb begin
      pr = pp_ff + 66'sh4000_0000;
      vx = {vhi_ff, 32'b0} + 95'(vlo_ff);
      ay = {a2_ff, 64'b0} + 127'({a1_ff, 32'b0}) + 127'(a0_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_vld_ff <= 1'b0;
      end else if (en) begin
         sd_vld_ff <= sc_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_done_ff <= sc_done_ff;
         sd_cneg_ff <= sc_cneg_ff;
         sd_pos_ff  <= start_ff + 32'(pr >>> 31);
         sd_vnum_ff <= 52'(vx[93:44]);
         sd_anum_ff <= ay[125:74];
      end
   end

   // Divide velocity by T and acceleration by T squared.
   logic        vel_vld;
   logic [51:0] vel_q;
   logic [32:0] vel_side;
   logic        acc_vld;
   logic [51:0] acc_q;
   logic        acc_cneg;

   cmp_div #(
      .QUO_W  (52),
      .DEN_W  (24),
      .SIDE_W (33)
   ) u_vel_div (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (sd_vld_ff),
      .rem_i  ('0),
      .num_i  (sd_vnum_ff),
      .den_i  (teff),
      .side_i ({sd_done_ff, sd_pos_ff}),
      .vld_o  (vel_vld),
      .quo_o  (vel_q),
      .side_o (vel_side)
   );

   cmp_div #(
      .QUO_W  (52),
      .DEN_W  (48),
      .SIDE_W (1)
   ) u_acc_div (
      .clock  (clock),
      .reset  (reset),
      .en     (en),
      .vld_i  (sd_vld_ff),
      .rem_i  ('0),
      .num_i  (sd_anum_ff),
      .den_i  (tsq_ff),
      .side_i (sd_cneg_ff),
      .vld_o  (acc_vld),
      .quo_o  (acc_q),
      .side_o (acc_cneg)
   );

   // Final result and output queue.
   cmp_rsp_type res;
   cmp_rsp_type fifo_ff [2];
   logic        wptr_ff;
   logic        rptr_ff;
   logic        wr;
   logic        rd;

   always_comb begin
      res.done = vel_side[32];
      if (vel_side[32]) begin
         res.pos = end_ff;
         res.vel = '0;
         res.acc = '0;
      end else begin
         res.pos = vel_side[31:0];
         res.vel = sat48(difneg_ff, vel_q);
         res.acc = sat48(difneg_ff ^ acc_cneg, acc_q);
      end
   end

   assign wr = en && vel_vld;
   assign rd = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (wr) begin
         fifo_ff[wptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (wr) wptr_ff <= ~wptr_ff;
         if (rd) rptr_ff <= ~rptr_ff;
         priority if (wr && !rd) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (rd && !wr) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {fifo_ff[rptr_ff].acc, fifo_ff[rptr_ff].vel, fifo_ff[rptr_ff].pos};
   assign rsp_tuser  = fifo_ff[rptr_ff].done;

   a_div_aligned: assert property (@(posedge clock) disable iff (reset)
      vel_vld == acc_vld)
      else $error("velocity and acceleration dividers out of step");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[127:32] == '0)
      else $error("finished move reports nonzero velocity or acceleration");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s0_vld_ff)
      else $error("input transfer did not reach the first stage");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !wr)
      else $error("output queue written while full");

endmodule

// ----- bench/cosine_motion_profile_checker.sv -----
// Checker for the cosine motion profile: predicts every result and compares transfers.
module cosine_motion_profile_checker import cmp_pkg::*; #(
   parameter int PHASE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [23:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output int           fail_count,
   output int           pending_count
);

   localparam logic [191:0] SAT_POS_MAG = (192'd1 << 47) - 192'd1;
   localparam logic [191:0] SAT_NEG_MAG = 192'd1 << 47;

   logic signed [31:0] origin_pos;
   logic signed [31:0] end_pos;
   logic [23:0]        duration;
   cmp_rsp_type        expected_profile[$];

   function automatic logic [47:0] saturate48(input bit neg, input logic [191:0] mag);
      logic [191:0] limit;
      limit = neg ? SAT_NEG_MAG : SAT_POS_MAG;
      if (mag > limit) begin
         mag = limit;
      end
      return neg ? -mag[47:0] : mag[47:0];
   endfunction

   function automatic cmp_rsp_type predict_profile(input logic [23:0] ticks);
      cmp_rsp_type        r;
      longint             span, half, full, phase, x, y, z, dx, dy, c_signed, delta;
      logic [63:0]        mag;
      logic signed [95:0] prod;
      logic [191:0]       wide, shifted;
      bit                 cos_neg, neg;
      full = longint'(1) << PHASE_BITS;
      half = full >> 1;
      span = (duration == 24'd0) ? 1 : longint'(duration);
      r = '0;
      if (longint'(ticks) > span) begin
         r.pos  = end_pos;
         r.done = 1'b1;
         return r;
      end
      phase = ((longint'(ticks) << PHASE_BITS) + (span >> 1)) / span;
      cos_neg = 1'b0;
      if (phase > half) begin
         phase   = full - phase;
         cos_neg = 1'b1;
      end
      z = (phase * longint'(PI_Q30) + half) >>> PHASE_BITS;
      x = longint'(CORDIC_GAIN);
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(ATAN_Q30[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(ATAN_Q30[i]);
         end
      end
      if (x < 0) x = 0;
      if (x > longint'(ONE_Q30)) x = longint'(ONE_Q30);
      if (y < 0) y = 0;
      if (y > longint'(ONE_Q30)) y = longint'(ONE_Q30);
      c_signed = cos_neg ? -x : x;

      delta = longint'(end_pos) - longint'(origin_pos);
      neg   = delta < 0;
      mag   = neg ? -delta : delta;

      prod  = 96'(delta) * 96'(longint'(ONE_Q30) - c_signed);
      prod  = (prod + 96'sd1073741824) >>> 31;
      r.pos = 32'(96'(origin_pos) + prod);

      wide    = 192'(mag) * 192'(y);
      wide    = wide * 192'(PI_Q30);
      wide    = wide / 192'(span);
      wide    = wide + (192'd1 << 44);
      shifted = wide >> 45;
      r.vel   = saturate48(neg, shifted);

      wide    = 192'(mag) * 192'(x);
      wide    = wide * 192'(PI_Q30);
      wide    = wide * 192'(PI_Q30);
      wide    = wide / 192'(span);
      wide    = wide / 192'(span);
      wide    = wide + (192'd1 << 74);
      shifted = wide >> 75;
      r.acc   = saturate48(neg != cos_neg, shifted);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %0s at %0t: got %0h, expected %0h", field, $time, got, want);
      fail_count++;
   endtask

   assign pending_count = expected_profile.size();

   always @(posedge clock) begin
      cmp_rsp_type got, want;
      if (reset) begin
         origin_pos <= '0;
         end_pos    <= '0;
         duration   <= 24'd1;
         expected_profile.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_START:    origin_pos <= csr_wdata;
               CSR_END:      end_pos    <= csr_wdata;
               CSR_DURATION: duration   <= csr_wdata[23:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_profile.push_back(predict_profile(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_profile.size() == 0) begin
               report_mismatch("unexpected transfer", 64'(got.pos), 64'd0);
            end else begin
               want = expected_profile.pop_front();
               if (got.pos !== want.pos) report_mismatch("position", got.pos, want.pos);
               if (got.vel !== want.vel) report_mismatch("velocity", got.vel, want.vel);
               if (got.acc !== want.acc) report_mismatch("acceleration", got.acc, want.acc);
               if (got.done !== want.done) report_mismatch("move_done", got.done, want.done);
            end
         end
      end
   end

endmodule

// ----- bench/tb_cosine_motion_profile.sv -----
// Testbench top for the cosine motion profile: clock, reset, stimulus and verdict.
module tb_cosine_motion_profile import cmp_pkg::*;;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int         WATCHDOG_LIMIT = 3000;
   localparam int         HOLD_CYCLES = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_wr_en = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;
   int           fail_count;
   int           pending_count;
   int           idle_pct = 0;
   int           stall_pct = 0;
   bit           hold_go = 1'b0;
   int           quiet_cycles = 0;
   logic [23:0]  move_len = 24'd1;

   always #6 clock = ~clock;

   cosine_motion_profile dut (.*);

   cosine_motion_profile_checker checker_i (.*);

   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_ticks(input logic [23:0] ticks);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ticks;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_DURATION) begin
         move_len = (value[23:0] == 24'd0) ? 24'd1 : value[23:0];
      end
   endtask

   function automatic logic [31:0] pick_position();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(200000) - 100000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [23:0] pick_duration();
      case ($urandom_range(4))
         0: return 24'd1;
         1: return 24'($urandom_range(64, 1));
         2: return 24'($urandom_range(5000, 1));
         3: return 24'hff_ffff;
         default: return 24'($urandom_range(24'hff_ffff, 1));
      endcase
   endfunction

   function automatic logic [23:0] pick_ticks();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return 24'($urandom_range(move_len));
      if (sel < 85) return 24'(move_len + $urandom_range(2) - 1);
      return 24'($urandom);
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_ticks(24'd0);
      send_ticks(24'd1);
      send_ticks(24'd2);
      drain();
      write_csr(CSR_DURATION, 32'd0);
      write_csr(CSR_UNUSED, 32'hffff_ffff);
      send_ticks(24'd0);
      send_ticks(24'd1);
      send_ticks(24'd2);
      drain();
      write_csr(CSR_START, 32'h8000_0000);
      write_csr(CSR_END, 32'h7fff_ffff);
      write_csr(CSR_DURATION, 32'h00ff_ffff);
      send_ticks(24'd0);
      send_ticks(24'h7f_ffff);
      send_ticks(24'hff_ffff);
      drain();
      write_csr(CSR_DURATION, 32'd1000);
      for (int i = 0; i <= 1000; i += 250) send_ticks(24'(i));
      send_ticks(24'd1001);
      send_ticks(24'hff_ffff);
      drain();
      write_csr(CSR_START, 32'h7fff_ffff);
      write_csr(CSR_END, 32'h8000_0000);
      write_csr(CSR_DURATION, 32'd1);
      send_ticks(24'd0);
      send_ticks(24'd1);
      drain();

      for (int phase_num = 0; phase_num < 8; phase_num++) begin
         write_csr(CSR_START, pick_position());
         write_csr(CSR_END, pick_position());
         write_csr(CSR_DURATION, 32'(pick_duration()));
         case (phase_num % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         if (phase_num == 0) hold_go = 1'b1;
         repeat (128) send_ticks(pick_ticks());
         drain();
      end

      repeat (120) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
